// File: sv/pe_image_checksum_macros.svh
`ifndef PE_IMAGE_CHECKSUM_MACROS_SVH
`define PE_IMAGE_CHECKSUM_MACROS_SVH

// Checks a property on every rising edge outside reset
`define PIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising edge, reset included
`define PIC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/pic_pkg.sv
package pic_pkg;

  // Widths fixed by the stream format
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SumW   = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  // Register map (word index = paddr[AddrW-1:2])
  localparam logic [AddrW-3:0] RegChecksumOffset = 1'b0;

  localparam logic [CountW-1:0] OffsetReset = 32'd64;
  localparam logic [CountW-1:0] SkipLen     = 32'd4;

  // One request on the input channel
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             in_signature;
    logic             last_byte;
  } pic_item_t;

  // 16-bit add with the carry folded back in
  function automatic logic [SumW-1:0] fold_add(input logic [SumW-1:0] acc,
                                               input logic [SumW-1:0] word);
    logic [SumW:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
  endfunction

endpackage

// File: sv/pic_cfg.sv
module pic_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pic_pkg::AddrW-1:0]  paddr,
  input  logic [pic_pkg::DataW-1:0]  pwdata,
  output logic [pic_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [pic_pkg::CountW-1:0] field_offset
);
  import pic_pkg::*;

  logic [CountW-1:0] offset_r;
  logic              hit;

  assign pready = 1'b1;
  assign hit    = (paddr[AddrW-1:2] == RegChecksumOffset);

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OffsetReset;
    end else if (psel && penable && pwrite && pready && hit) begin
      offset_r <= pwdata;
    end
  end

  // Read mux; unmapped words read zero
  always_comb begin
    prdata = hit ? offset_r : '0;
  end

  assign field_offset = offset_r;

endmodule

// File: sv/pic_in_reg.sv
module pic_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pic_pkg::pic_item_t  in_item,
  output logic                item_valid,
  output pic_pkg::pic_item_t  item,
  input  logic                item_take
);
  import pic_pkg::*;

  logic      valid_r;
  pic_item_t item_r;

  // Refill in the same cycle the held request is consumed
  assign in_ready = !valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: sv/pic_accum.sv
module pic_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  pic_pkg::pic_item_t         item,
  output logic                       item_take,
  input  logic                       res_free,
  input  logic [pic_pkg::CountW-1:0] field_offset,
  output logic                       res_load,
  output logic [pic_pkg::CountW-1:0] res_value
);
  import pic_pkg::*;

  logic [SumW-1:0]   sum_r, sum_nxt;
  logic [ByteW-1:0]  held_r, held_nxt;
  logic              hb_r, hb_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              seen_r, seen_nxt;

  logic [CountW-1:0] pos_inc;
  logic [CountW-1:0] win_dist;
  logic              in_win;
  logic              sig_start;
  logic              do_flush;
  logic              do_take;
  logic [SumW-1:0]   word_a;
  logic [SumW-1:0]   sum_a;
  logic [ByteW-1:0]  held_a;
  logic              hb_a;

  // A final byte waits until the result register is free
  assign item_take = item_valid && (!item.last_byte || res_free);
  assign res_load  = item_take && item.last_byte;

  assign pos_inc  = count_r + 32'd1;
  assign win_dist = count_r - field_offset;
  assign in_win   = (win_dist < SkipLen);

  // One byte: region flush, pairing, end-of-stream flush
  always_comb begin
    sig_start = item.in_signature && !seen_r;
    seen_nxt  = seen_r || item.in_signature;
    do_flush  = sig_start || (!seen_nxt && in_win);
    do_take   = seen_nxt || !in_win;

    // First add: either the held byte alone or a complete pair
    word_a = do_flush ? {{ByteW{1'b0}}, held_r} : {item.data_byte, held_r};
    sum_a  = (hb_r && (do_flush || do_take)) ? fold_add(sum_r, word_a) : sum_r;

    if (do_take && (do_flush || !hb_r)) begin
      held_a = item.data_byte;
      hb_a   = 1'b1;
    end else begin
      held_a = '0;
      hb_a   = 1'b0;
    end

    // Odd byte at the stream end goes in alone
    if (item.last_byte && hb_a) begin
      sum_nxt = fold_add(sum_a, {{ByteW{1'b0}}, held_a});
    end else begin
      sum_nxt = sum_a;
    end

    res_value = {{(CountW-SumW){1'b0}}, sum_nxt} + pos_inc;

    if (item.last_byte) begin
      sum_nxt   = '0;
      held_nxt  = '0;
      hb_nxt    = 1'b0;
      count_nxt = '0;
      seen_nxt  = 1'b0;
    end else begin
      held_nxt  = held_a;
      hb_nxt    = hb_a;
      count_nxt = pos_inc;
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      held_r  <= '0;
      hb_r    <= 1'b0;
      count_r <= '0;
      seen_r  <= 1'b0;
    end else if (item_take) begin
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
      hb_r    <= hb_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
    end
  end

`include "pe_image_checksum_macros.svh"

  `PIC_ASSERT(a_count_clears, item_take && item.last_byte |=> count_r == '0, "count not cleared")
  `PIC_ASSERT(a_count_steps, item_take && !item.last_byte |=> count_r == $past(count_r) + 32'd1, "count step")
  `PIC_ASSERT(a_held_zero, !hb_r |-> held_r == '0, "stale held byte")
  `PIC_ASSERT(a_sig_rise, $rose(seen_r) |-> $past(item_take && item.in_signature), "signature flag rose without signature byte")

endmodule

// File: sv/pic_out_reg.sv
module pic_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       res_load,
  input  logic [pic_pkg::CountW-1:0] res_value,
  output logic                       res_free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pic_pkg::CountW-1:0] out_checksum_value
);
  import pic_pkg::*;

  logic              valid_r;
  logic [CountW-1:0] value_r;

  // Free when empty or draining this cycle
  assign res_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      value_r <= res_value;
    end
  end

  assign out_valid          = valid_r;
  assign out_checksum_value = value_r;

endmodule

// File: sv/pe_image_checksum.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | in_data_byte[7:0], in_signature, in_last_byte
// out      | out_valid / out_ready| out_checksum_value[31:0]
// config   | psel/penable/pwrite  | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One byte per cycle sustained while the result register can take each final byte;
// out_valid rises once the last byte of a stream has passed the input register
// and its result is loaded into the result register. The two registers sit
// around the combinational fold-add step.
// rst_n is synchronous; it clears the stream state and sets the offset to 64.
// A stalled result holds a final byte in the input register, which then blocks
// the bytes behind it; non-final bytes ahead of it keep flowing.
module pe_image_checksum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pic_pkg::ByteW-1:0]  in_data_byte,
  input  logic                       in_signature,
  input  logic                       in_last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pic_pkg::CountW-1:0] out_checksum_value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pic_pkg::AddrW-1:0]  paddr,
  input  logic [pic_pkg::DataW-1:0]  pwdata,
  output logic [pic_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import pic_pkg::*;

  pic_item_t         in_item;
  pic_item_t         item;
  logic              item_valid;
  logic              item_take;
  logic              res_free;
  logic              res_load;
  logic [CountW-1:0] res_value;
  logic [CountW-1:0] field_offset;

  assign in_item = '{data_byte: in_data_byte, in_signature: in_signature,
                     last_byte: in_last_byte};

  pic_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .field_offset (field_offset)
  );

  pic_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  pic_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take),
    .res_free     (res_free),
    .field_offset (field_offset),
    .res_load     (res_load),
    .res_value    (res_value)
  );

  pic_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_load           (res_load),
    .res_value          (res_value),
    .res_free           (res_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_checksum_value (out_checksum_value)
  );

endmodule
